@@ rtl/positional_insert_delete_list_top_macros.svh @@
// Assertion macros shared by the positional list RTL.
// Used by positional_insert_delete_list_top.sv; no other dependencies.
`ifndef POSITIONAL_INSERT_DELETE_LIST_TOP_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PIDL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PIDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pidl_pkg.sv @@
// Shared types and codes for the positional list block.
// No dependencies; imported by pidl_cell and the top level.
`default_nettype none

package pidl_pkg;

  localparam int unsigned POS_W   = 7;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 8;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_ERASE  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic insert_en;
    logic erase_en;
    logic read_en;
  } pidl_cmd_t;

endpackage

`default_nettype wire

@@ rtl/pidl_cell.sv @@
// One list entry of the cell row: holds a word and shifts with its neighbors.
// Depends on pidl_pkg for the command struct.
`default_nettype none

module pidl_cell import pidl_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IW         = 8,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  wire pidl_cmd_t             cmd_i,
  input  wire logic [IW-1:0]         pos_i,
  input  wire logic [DATA_WIDTH-1:0] word_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  output logic      [DATA_WIDTH-1:0] data_o,
  output logic      [DATA_WIDTH-1:0] rd_o
);

  localparam logic [IW-1:0] Idx = IW'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  // Insert pulls from the lower neighbor above the position; erase pulls
  // from the upper neighbor at and above it.
  always_comb begin
    data_d = data_q;
    if (cmd_i.insert_en) begin
      if (Idx > pos_i) begin
        data_d = left_i;
      end else if (Idx == pos_i) begin
        data_d = word_i;
      end
    end else if (cmd_i.erase_en && (Idx >= pos_i)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (cmd_i.read_en && (Idx == pos_i)) ? data_q : '0;

endmodule

`default_nettype wire

@@ rtl/positional_insert_delete_list_top.sv @@
// A result is registered in the group words and the status when its request
// is accepted, then in the output register once that is free or being emptied.
// The block takes one request at a time; the cell row updates when a request is
// accepted, and the registered read-out OR tree settles before the result is loaded.
// Reset clears the entry count, the control state and the output valid;
// the entry words themselves are left as they are, since only entries below
// the count are ever read.
`default_nettype none

module positional_insert_delete_list_top import pidl_pkg::*; #(
  parameter int unsigned CAPACITY   = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // position[6:0], value[38:7], zero pad
  input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata    // read_value[31:0], list_length[39:32],
                                           // is_empty[40], status[42:41], zero pad
);

  `include "positional_insert_delete_list_top_macros.svh"

  // Count holds 0..CAPACITY; index compares run at the wider of count and
  // the position field.
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned IW   = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned GRP  = 16;
  localparam int unsigned NGRP = (CAPACITY + GRP - 1) / GRP;

  // Two-state sequencer: idle takes a request, pending hands the result over.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_PEND = 1'b1;

  logic                  state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [1:0]            st_q, st_d;
  logic [DATA_WIDTH-1:0] grp_q [NGRP];
  logic [DATA_WIDTH-1:0] grp_d [NGRP];

  logic                  out_valid_q;
  logic [47:0]           out_data_q;

  logic                  accept, load_out;
  logic [1:0]            kind;
  logic [IW-1:0]         pos_in, pos_eff, cnt_ext;
  logic                  is_ins, is_full, op_ok;
  logic [DATA_WIDTH-1:0] word;
  pidl_cmd_t             cmd;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_word;
  logic [VALUE_W-1:0]    rd_value;

  // A request is taken only while idle; the block works on one at a time.
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign kind    = s_axis_tuser;
  assign pos_in  = IW'(s_axis_tdata[POS_W-1:0]);
  assign cnt_ext = IW'(cnt_q);
  assign is_full = (cnt_q == CW'(CAPACITY));
  assign is_ins  = (kind == KIND_INSERT) || (kind == KIND_APPEND);
  // Append is an insert at the current end of the list.
  assign pos_eff = (kind == KIND_APPEND) ? cnt_ext : pos_in;

  // Incoming value is sign-extended or truncated to the stored word width.
  generate
    if (DATA_WIDTH > VALUE_W) begin : g_word_ext
      assign word = {{(DATA_WIDTH - VALUE_W){s_axis_tdata[POS_W+VALUE_W-1]}},
                     s_axis_tdata[POS_W+VALUE_W-1:POS_W]};
    end else begin : g_word_trunc
      assign word = s_axis_tdata[POS_W+DATA_WIDTH-1:POS_W];
    end
  endgenerate

  // The full check comes before the position check for inserts. A failed
  // operation leaves the row and the count untouched.
  always_comb begin
    if (is_ins) begin
      if (is_full) begin
        st_d = ST_FULL;
      end else if (pos_eff > cnt_ext) begin
        st_d = ST_RANGE;
      end else begin
        st_d = ST_OK;
      end
    end else begin
      st_d = (pos_in >= cnt_ext) ? ST_RANGE : ST_OK;
    end
  end

  assign op_ok         = (st_d == ST_OK);
  assign cmd.insert_en = accept && is_ins && op_ok;
  assign cmd.erase_en  = accept && (kind == KIND_ERASE) && op_ok;
  assign cmd.read_en   = accept && (kind == KIND_READ) && op_ok;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd.insert_en) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd.erase_en) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  // The row of cells: each entry talks only to its two neighbors. The end
  // cells feed back their own word where no neighbor exists.
  generate
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w, right_w;
      if (j == 0) begin : g_first
        assign left_w = cell_data[j];
      end else begin : g_mid_l
        assign left_w = cell_data[j-1];
      end
      if (j == CAPACITY - 1) begin : g_last
        assign right_w = cell_data[j];
      end else begin : g_mid_r
        assign right_w = cell_data[j+1];
      end
      pidl_cell #(
        .DATA_WIDTH(DATA_WIDTH),
        .IW        (IW),
        .INDEX     (j)
      ) u_cell (
        .clk_i  (clk_i),
        .cmd_i  (cmd),
        .pos_i  (pos_eff),
        .word_i (word),
        .left_i (left_w),
        .right_i(right_w),
        .data_o (cell_data[j]),
        .rd_o   (cell_rd[j])
      );
    end
  endgenerate

  // First level of the read-out tree: at most one cell drives a nonzero
  // word, so an OR per group of sixteen cells collects it.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
    end
    for (int j = 0; j < CAPACITY; j++) begin
      grp_d[j / GRP] = grp_d[j / GRP] | cell_rd[j];
    end
  end

  // Second level, read from the registered group words.
  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word = rd_word | grp_q[g];
    end
  end

  generate
    if (DATA_WIDTH >= VALUE_W) begin : g_rd_trunc
      assign rd_value = rd_word[VALUE_W-1:0];
    end else begin : g_rd_ext
      assign rd_value = {{(VALUE_W - DATA_WIDTH){rd_word[DATA_WIDTH-1]}}, rd_word};
    end
  endgenerate

  // The result moves into the output register once the slot is free or
  // being emptied in the same cycle.
  assign load_out = (state_q == S_PEND) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_PEND;
        end
      end
      S_PEND: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers; the count is already updated when the result leaves.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q <= st_d;
      for (int g = 0; g < NGRP; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end
    if (load_out) begin
      out_data_q <= {5'd0, st_q, (cnt_q == '0), LEN_W'(cnt_q), rd_value};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `PIDL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(CAPACITY), "entry count above capacity")
  `PIDL_ASSERT_NEXT(a_cnt_hold, !accept, $stable(cnt_q), "count moved without a request")
  `PIDL_ASSERT_NEXT(a_acc_pend, accept, state_q == S_PEND, "accepted request not pending")
  `PIDL_ASSERT_NOW(a_one_op, accept, !(cmd.insert_en && cmd.erase_en), "insert and erase at once")

endmodule

`default_nettype wire

@@ tb/sv/positional_insert_delete_list_checker.sv @@
// Scoreboard for the positional list block: predicts one result per accepted
// request and compares it with the result stream. Depends on pidl_pkg.
`default_nettype none

module positional_insert_delete_list_checker import pidl_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [39:0] s_tdata_i,   // position[6:0], value[38:7], zero pad
  input  wire logic [1:0]  s_tuser_i,   // kind[1:0]
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [47:0] m_tdata_i,   // read_value[31:0], list_length[39:32],
                                        // is_empty[40], status[42:41], zero pad
  output int unsigned      mismatches_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [LEN_W-1:0]          list_length;
    logic                      is_empty;
    logic [1:0]                status;
  } list_result_t;

  logic [VALUE_W-1:0] list_words [CAPACITY];
  int unsigned        list_len;
  list_result_t       expected_q [$];
  int unsigned        mismatch_cnt;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = expected_q.size();

  initial begin
    list_len     = 0;
    mismatch_cnt = 0;
  end

  // Applies one list operation to the shadow list and returns its result.
  function automatic list_result_t apply_list_op(logic [1:0] kind, logic [POS_W-1:0] pos,
                                                 logic [VALUE_W-1:0] value);
    list_result_t res;
    int unsigned  idx;
    res        = '0;
    res.status = ST_OK;
    idx        = pos;
    if (kind == KIND_APPEND) begin
      idx = list_len;
    end
    case (kind)
      KIND_INSERT, KIND_APPEND: begin
        // A full list wins over a bad position.
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (idx > list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int j = list_len; j > idx; j--) list_words[j] = list_words[j-1];
          list_words[idx] = value;
          list_len++;
        end
      end
      KIND_ERASE: begin
        if (idx >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int j = idx; j + 1 < list_len; j++) list_words[j] = list_words[j+1];
          list_len--;
        end
      end
      default: begin
        if (idx >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = list_words[idx];
        end
      end
    endcase
    res.list_length = list_len[LEN_W-1:0];
    res.is_empty    = (list_len == 0);
    return res;
  endfunction

  always @(posedge clk_i) begin
    list_result_t want;
    list_result_t got;
    if (rst_ni) begin
      // Results first: a request accepted now cannot produce a result this edge.
      if (m_tvalid_i && m_tready_i) begin
        got.read_value  = m_tdata_i[31:0];
        got.list_length = m_tdata_i[39:32];
        got.is_empty    = m_tdata_i[40];
        got.status      = m_tdata_i[42:41];
        if (expected_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = expected_q.pop_front();
          if (got.read_value !== want.read_value) begin
            mismatch_cnt++;
            $display("%0t: read_value expected %0d actual %0d", $time,
                     want.read_value, got.read_value);
          end
          if (got.list_length !== want.list_length) begin
            mismatch_cnt++;
            $display("%0t: list_length expected %0d actual %0d", $time,
                     want.list_length, got.list_length);
          end
          if (got.is_empty !== want.is_empty) begin
            mismatch_cnt++;
            $display("%0t: is_empty expected %0d actual %0d", $time,
                     want.is_empty, got.is_empty);
          end
          if (got.status !== want.status) begin
            mismatch_cnt++;
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, got.status);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_q.push_back(apply_list_op(s_tuser_i, s_tdata_i[6:0], s_tdata_i[38:7]));
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/positional_insert_delete_list_top_tb.sv @@
// Top of the positional list testbench: clock, reset, request stimulus and
// the verdict. Depends on pidl_pkg, the block and positional_insert_delete_list_checker.
`default_nettype none

module positional_insert_delete_list_top_tb import pidl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY   = 128;
  // Cycles without any handshake on either side before the run is abandoned.
  // The longest legal quiet stretch is the receiver hold-off below.
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  int unsigned mismatches;
  int unsigned pending;

  // Idling controls, set by the stimulus process and read by the drivers.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_req        = 0;

  // Length of the list as the stimulus sees it, used only to steer positions
  // into the legal range most of the time.
  int unsigned shadow_len = 0;
  int unsigned sent_cnt   = 0;
  int unsigned quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  positional_insert_delete_list_top #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (VALUE_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  positional_insert_delete_list_checker #(
    .CAPACITY (CAPACITY)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Receiver: stalls at random at the current rate. When a hold-off is asked
  // for, tready stays low for the whole stretch, counted here, so that the
  // block backs up and drops its own tready while the sender keeps offering.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any handshake on either side restarts the count. The run is
  // ended with a failure if the count ever reaches the limit.
  initial begin
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL positional_insert_delete_list_top");
    $finish;
  end

  // Offers one request and returns at the edge where it is accepted. Gaps are
  // inserted before the request at the sender's rate, except in the first
  // few requests of every block of forty, which go back to back. Valid stays
  // high from one request to the next when no gap falls between them.
  task automatic send_request(logic [1:0] kind, logic [POS_W-1:0] pos,
                              logic [VALUE_W-1:0] value);
    if ((sent_cnt % 40) >= 8) begin
      while ($urandom_range(99) < sender_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, value, pos};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_cnt++;
    // Track the length so that later positions can be aimed at the list.
    case (kind)
      KIND_INSERT: if (shadow_len < CAPACITY && pos <= shadow_len) shadow_len++;
      KIND_APPEND: if (shadow_len < CAPACITY) shadow_len++;
      KIND_ERASE:  if (pos < shadow_len) shadow_len--;
      default: ;
    endcase
  endtask

  // Picks a random operation from the given mix. Most positions fall inside
  // the legal range for the operation; about one in ten is drawn from the
  // whole field to hit the out-of-range path. Values lean on the extremes now
  // and then.
  task automatic random_request(int unsigned grow_pct, int unsigned erase_pct);
    logic [1:0]         kind;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    int unsigned        pick;
    pick = $urandom_range(99);
    if (pick < grow_pct) begin
      kind = ($urandom_range(1) == 0) ? KIND_INSERT : KIND_APPEND;
    end else if (pick < grow_pct + erase_pct) begin
      kind = KIND_ERASE;
    end else begin
      kind = KIND_READ;
    end
    if ($urandom_range(9) == 0) begin
      pos = POS_W'($urandom_range(127));
    end else if (kind == KIND_INSERT || kind == KIND_APPEND) begin
      pos = POS_W'((shadow_len >= CAPACITY) ? $urandom_range(127)
                                            : $urandom_range(shadow_len));
    end else begin
      pos = POS_W'((shadow_len == 0) ? $urandom_range(127)
                                     : $urandom_range(shadow_len - 1));
    end
    case ($urandom_range(19))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7fff_ffff;
      2:       value = 32'h0000_0000;
      3:       value = 32'hffff_ffff;
      default: value = $urandom;
    endcase
    send_request(kind, pos, value);
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_READ;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling. Operations on the empty list all fail with
    // a range error, then the list is built up with extreme values, read at
    // both ends and just past them, and shrunk again from the back and front.
    send_request(KIND_READ,   7'd0,   32'h0000_0000);
    send_request(KIND_ERASE,  7'd0,   32'h0000_0000);
    send_request(KIND_READ,   7'd127, 32'hffff_ffff);
    send_request(KIND_INSERT, 7'd1,   32'h1111_1111);
    send_request(KIND_INSERT, 7'd0,   32'h8000_0000);
    send_request(KIND_APPEND, 7'd127, 32'h7fff_ffff);
    send_request(KIND_APPEND, 7'd0,   32'hffff_ffff);
    send_request(KIND_INSERT, 7'd1,   32'h0000_0000);
    // Insert at a position equal to the length acts as an append.
    send_request(KIND_INSERT, 7'd4,   32'h1234_5678);
    send_request(KIND_INSERT, 7'd6,   32'h5555_5555);
    send_request(KIND_READ,   7'd0,   32'hffff_ffff);
    send_request(KIND_READ,   7'd1,   32'h0000_0000);
    send_request(KIND_READ,   7'd4,   32'h0000_0000);
    send_request(KIND_READ,   7'd5,   32'h0000_0000);
    send_request(KIND_ERASE,  7'd5,   32'h0000_0000);
    send_request(KIND_ERASE,  7'd4,   32'h0000_0000);
    send_request(KIND_ERASE,  7'd0,   32'h0000_0000);
    send_request(KIND_READ,   7'd0,   32'h0000_0000);
    send_request(KIND_READ,   7'd2,   32'h0000_0000);
    send_request(KIND_ERASE,  7'd1,   32'h0000_0000);
    send_request(KIND_ERASE,  7'd0,   32'h0000_0000);
    send_request(KIND_ERASE,  7'd0,   32'h0000_0000);
    send_request(KIND_ERASE,  7'd0,   32'h0000_0000);

    // Fill to capacity with the receiver stalling at random. A long hold-off
    // at the start makes the block back up against the sender. Once full, a
    // dozen more requests exercise the full-list error on insert and append.
    recv_stall_pct = 49;
    hold_req = HOLD_CYCLES;
    while (shadow_len < CAPACITY) random_request(90, 2);
    repeat (12) random_request(90, 2);

    // Balanced traffic around the top of the list, both sides idling lightly.
    sender_idle_pct = 14;
    recv_stall_pct  = 14;
    repeat (40) random_request(40, 30);

    // Drain to empty with the sender idling, then keep poking the empty list.
    sender_idle_pct = 49;
    recv_stall_pct  = 0;
    while (shadow_len > 0) random_request(5, 80);
    repeat (10) random_request(5, 80);

    // Balanced traffic from empty, no idling at all.
    sender_idle_pct = 0;
    repeat (40) random_request(45, 35);

    s_axis_tvalid <= 1'b0;

    // Wait for every outstanding result, then a few cycles more so that any
    // stray result from the block's registered pipeline still gets caught.
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("PASS positional_insert_delete_list_top");
    end else begin
      $display("FAIL positional_insert_delete_list_top");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/pidl_pkg.sv
rtl/pidl_cell.sv
rtl/positional_insert_delete_list_top.sv
tb/sv/positional_insert_delete_list_checker.sv
tb/sv/positional_insert_delete_list_top_tb.sv
